>>> sv/btb_two_level_branch_predictor_macros.svh
// Assertion macros used by the predictor controller RTL.
`ifndef BTB_TWO_LEVEL_BRANCH_PREDICTOR_MACROS_SVH
`define BTB_TWO_LEVEL_BRANCH_PREDICTOR_MACROS_SVH
`ifndef SYNTHESIS
`define BTB_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BTB_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BTB_CHECK(lbl, prop, msg)
`define BTB_CHECK_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> sv/btb_pkg.sv
package btb_pkg;

  localparam int BTB_DEPTH_DEF = 32;
  localparam int HIST_MAX_DEF  = 8;
  localparam int TAG_W         = 30;
  localparam int PC_W          = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 8;
  localparam int IDX_LSB       = 2;
  localparam int XOR_HI_LSB    = 16;
  localparam logic [PC_W-1:0] PC_STEP = 32'd4;

  typedef enum logic [2:0] {
    CFG_SIZE_LOG2  = 3'd0,
    CFG_HIST_LEN   = 3'd1,
    CFG_TAG_WIDTH  = 3'd2,
    CFG_FSM_INIT   = 3'd3,
    CFG_GLOBAL_HIST = 3'd4,
    CFG_GLOBAL_TAB = 3'd5,
    CFG_SHARE_MODE = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SHARE_NONE = 2'd0,
    SHARE_LO   = 2'd1,
    SHARE_HI   = 2'd2
  } share_t;

  localparam logic MODE_PREDICT = 1'b0;
  localparam logic MODE_UPDATE  = 1'b1;

  localparam logic [1:0] CTR_MIN = 2'd0;
  localparam logic [1:0] CTR_MAX = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENT,
    ST_FILL,
    ST_CRD,
    ST_CTR
  } state_t;

  typedef struct packed {
    logic re;
    logic we;
  } mem_cmd_t;

  function automatic logic [1:0] ctr_train(input logic [1:0] c, input logic tk);
    logic [1:0] r;
    if (tk) begin
      r = (c == CTR_MAX) ? c : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? c : c - 2'd1;
    end
    return r;
  endfunction

endpackage

>>> sv/btb_if.sv
interface btb_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] pc;
  logic [31:0] target_pc;
  logic        taken;
  logic [31:0] prior_prediction;
  modport source (output valid, mode, pc, target_pc, taken, prior_prediction, input ready);
  modport sink (input valid, mode, pc, target_pc, taken, prior_prediction, output ready);
endinterface

interface btb_rsp_if;
  logic        valid;
  logic        ready;
  logic        predict_taken;
  logic [31:0] predicted_target;
  logic [31:0] branch_count;
  logic [31:0] flush_count;
  modport source (output valid, predict_taken, predicted_target, branch_count, flush_count,
                  input ready);
  modport sink (input valid, predict_taken, predicted_target, branch_count, flush_count,
                output ready);
endinterface

interface btb_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/btb_entry_mem.sv
module btb_entry_mem #(
  parameter int BTB_DEPTH = btb_pkg::BTB_DEPTH_DEF,
  parameter int HIST_MAX  = btb_pkg::HIST_MAX_DEF,
  parameter int IDX_W     = (BTB_DEPTH > 1) ? $clog2(BTB_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  btb_pkg::mem_cmd_t         cmd,
  input  logic [IDX_W-1:0]          raddr,
  input  logic [IDX_W-1:0]          waddr,
  input  logic [btb_pkg::TAG_W-1:0] wtag,
  input  logic [31:0]               wtarget,
  input  logic [HIST_MAX-1:0]       whist,
  output logic                      rvalid,
  output logic [btb_pkg::TAG_W-1:0] rtag,
  output logic [31:0]               rtarget,
  output logic [HIST_MAX-1:0]       rhist
);

  localparam int DW = btb_pkg::TAG_W + 32 + HIST_MAX;

  logic [DW-1:0]        mem [BTB_DEPTH];
  logic [BTB_DEPTH-1:0] valid;
  logic [DW-1:0]        rd;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[waddr] <= {wtag, wtarget, whist};
    end
    if (cmd.re) begin
      rd     <= mem[raddr];
      rvalid <= valid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (cmd.we) begin
      valid[waddr] <= 1'b1;
    end
  end

  assign {rtag, rtarget, rhist} = rd;

endmodule

>>> sv/btb_ctr_mem.sv
module btb_ctr_mem #(
  parameter int BTB_DEPTH = btb_pkg::BTB_DEPTH_DEF,
  parameter int HIST_MAX  = btb_pkg::HIST_MAX_DEF,
  parameter int CS_W      = $clog2(BTB_DEPTH + 1),
  parameter int CA_W      = CS_W + HIST_MAX
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic [1:0]        init,
  input  btb_pkg::mem_cmd_t cmd,
  input  logic [CA_W-1:0]   raddr,
  input  logic [CA_W-1:0]   waddr,
  input  logic [1:0]        wdata,
  output logic [1:0]        rdata
);

  localparam int CDEPTH = (BTB_DEPTH + 1) << HIST_MAX;
  localparam int SH_N   = 1 << HIST_MAX;
  localparam logic [CS_W-1:0] SH_SLOT = CS_W'(BTB_DEPTH);

  logic [1:0]      mem [CDEPTH];
  logic [SH_N-1:0] sh_valid;
  logic [1:0]      rd;
  logic            rd_init;
  logic            r_sh;
  logic            w_sh;

  assign r_sh = (raddr[CA_W-1:HIST_MAX] == SH_SLOT);
  assign w_sh = (waddr[CA_W-1:HIST_MAX] == SH_SLOT);

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.re) begin
      rd      <= mem[raddr];
      rd_init <= r_sh && !sh_valid[raddr[HIST_MAX-1:0]];
    end
  end

  // Shared counters that were never written read as the initial state.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sh_valid <= '0;
    end else if (cmd.we && w_sh) begin
      sh_valid[waddr[HIST_MAX-1:0]] <= 1'b1;
    end
  end

  assign rdata = rd_init ? init : rd;

endmodule

>>> sv/btb_ctrl.sv
`include "btb_two_level_branch_predictor_macros.svh"

module btb_ctrl #(
  parameter int BTB_DEPTH = btb_pkg::BTB_DEPTH_DEF,
  parameter int HIST_MAX  = btb_pkg::HIST_MAX_DEF,
  parameter int IDX_W     = (BTB_DEPTH > 1) ? $clog2(BTB_DEPTH) : 1,
  parameter int CS_W      = $clog2(BTB_DEPTH + 1),
  parameter int CA_W      = CS_W + HIST_MAX
) (
  input  logic                      clk,
  input  logic                      rst,
  btb_req_if.sink                   req,
  btb_rsp_if.source                 rsp,
  btb_cfg_if.sink                   cfg,
  output logic                      clear,
  output logic [1:0]                fsm_init_o,
  output btb_pkg::mem_cmd_t         ent_cmd,
  output logic [IDX_W-1:0]          ent_raddr,
  output logic [IDX_W-1:0]          ent_waddr,
  output logic [btb_pkg::TAG_W-1:0] ent_wtag,
  output logic [31:0]               ent_wtarget,
  output logic [HIST_MAX-1:0]       ent_whist,
  input  logic                      ent_rvalid,
  input  logic [btb_pkg::TAG_W-1:0] ent_rtag,
  input  logic [31:0]               ent_rtarget,
  input  logic [HIST_MAX-1:0]       ent_rhist,
  output btb_pkg::mem_cmd_t         ctr_cmd,
  output logic [CA_W-1:0]           ctr_raddr,
  output logic [CA_W-1:0]           ctr_waddr,
  output logic [1:0]                ctr_wdata,
  input  logic [1:0]                ctr_rdata
);

  localparam int LMAX = $clog2(BTB_DEPTH + 1) - 1;
  localparam logic [CS_W-1:0] SH_SLOT = CS_W'(BTB_DEPTH);

  btb_pkg::state_t st, st_next;

  logic [2:0] size_log2;
  logic [3:0] hist_len;
  logic [4:0] tag_w;
  logic [1:0] fsm_init;
  logic       g_hist;
  logic       g_tab;
  logic [1:0] share;

  logic                      mode_q;
  logic [31:0]               pc_q;
  logic [31:0]               tgt_q;
  logic                      taken_q;
  logic [31:0]               prior_q;
  logic [IDX_W-1:0]          slot_q;
  logic [btb_pkg::TAG_W-1:0] tag_q;
  logic                      hit_q;
  logic [HIST_MAX-1:0]       hist_q;
  logic [HIST_MAX-1:0]       k_q;
  logic [HIST_MAX-1:0]       fill;
  logic [HIST_MAX-1:0]       shist;
  logic [31:0]               bcnt;
  logic [31:0]               fcnt;

  logic        out_v;
  logic        out_taken;
  logic [31:0] out_target;

  logic [3:0]                l_eff;
  logic [3:0]                hl;
  logic [4:0]                tw;
  logic [HIST_MAX:0]         one_sh;
  logic [HIST_MAX-1:0]       hmask;
  logic [31:0]               smask;
  logic [31:0]               tmask;
  logic [31:0]               tshift;
  logic [IDX_W-1:0]          slot_in;
  logic [btb_pkg::TAG_W-1:0] tag_in;
  logic [HIST_MAX-1:0]       xb;
  logic                      hit;
  logic [HIST_MAX-1:0]       h_eff;
  logic [HIST_MAX-1:0]       k_c;
  logic [CS_W-1:0]           cslot;
  logic                      need_fill;
  logic                      fire;
  logic [1:0]                trained;
  logic                      ptaken;
  logic [31:0]               fall;
  logic                      wrong;
  logic [HIST_MAX:0]         hs;
  logic [HIST_MAX-1:0]       hist_new;
  logic                      cfg_we;

  assign cfg_we     = cfg.valid && cfg.ready && (cfg.index <= btb_pkg::CFG_SHARE_MODE);
  assign clear      = cfg_we;
  assign fsm_init_o = fsm_init;
  assign cfg.ready  = 1'b1;

  always_comb begin
    l_eff = ({1'b0, size_log2} > 4'(LMAX)) ? 4'(LMAX) : {1'b0, size_log2};
    if (hist_len == 4'd0) begin
      hl = 4'd1;
    end else if (hist_len > 4'(HIST_MAX)) begin
      hl = 4'(HIST_MAX);
    end else begin
      hl = hist_len;
    end
    tw     = (tag_w > 5'(btb_pkg::TAG_W)) ? 5'(btb_pkg::TAG_W) : tag_w;
    one_sh = (HIST_MAX + 1)'(1) << hl;
    hmask  = one_sh[HIST_MAX-1:0] - HIST_MAX'(1);
    smask  = (32'd1 << l_eff) - 32'd1;
    tmask  = (32'd1 << tw) - 32'd1;
    slot_in = IDX_W'((req.pc >> btb_pkg::IDX_LSB) & smask);
    tshift  = req.pc >> (l_eff + 4'(btb_pkg::IDX_LSB));
    tag_in  = btb_pkg::TAG_W'(tshift & tmask);
    case (share)
      btb_pkg::SHARE_LO: xb = pc_q[btb_pkg::IDX_LSB +: HIST_MAX];
      btb_pkg::SHARE_HI: xb = pc_q[btb_pkg::XOR_HI_LSB +: HIST_MAX];
      default:           xb = '0;
    endcase
    hit = ent_rvalid && (ent_rtag == tag_q);
    if (g_hist) begin
      h_eff = shist;
    end else begin
      h_eff = hit ? ent_rhist : '0;
    end
    k_c       = (h_eff ^ xb) & hmask;
    cslot     = g_tab ? SH_SLOT : CS_W'(slot_q);
    need_fill = (mode_q == btb_pkg::MODE_UPDATE) && !hit && !g_tab;
    fire      = (st == btb_pkg::ST_CTR) && (!out_v || rsp.ready);
    trained   = btb_pkg::ctr_train(ctr_rdata, taken_q);
    ptaken    = hit_q && ctr_rdata[1];
    fall      = pc_q + btb_pkg::PC_STEP;
    wrong     = taken_q ? (prior_q != tgt_q) : (prior_q != fall);
    hs        = {hist_q, taken_q};
    hist_new  = hs[HIST_MAX-1:0] & hmask;
  end

  always_comb begin
    st_next = st;
    case (st)
      btb_pkg::ST_IDLE: if (req.valid) st_next = btb_pkg::ST_ENT;
      btb_pkg::ST_ENT:  st_next = need_fill ? btb_pkg::ST_FILL : btb_pkg::ST_CTR;
      btb_pkg::ST_FILL: if (&fill) st_next = btb_pkg::ST_CRD;
      btb_pkg::ST_CRD:  st_next = btb_pkg::ST_CTR;
      btb_pkg::ST_CTR:  if (fire) st_next = btb_pkg::ST_IDLE;
      default:          st_next = btb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready   = (st == btb_pkg::ST_IDLE);
    ent_cmd.re  = (st == btb_pkg::ST_IDLE) && req.valid;
    ent_cmd.we  = fire && (mode_q == btb_pkg::MODE_UPDATE);
    ent_raddr   = slot_in;
    ent_waddr   = slot_q;
    ent_wtag    = tag_q;
    ent_wtarget = tgt_q;
    ent_whist   = hist_new;
    ctr_cmd.re  = ((st == btb_pkg::ST_ENT) && !need_fill) || (st == btb_pkg::ST_CRD);
    ctr_cmd.we  = (st == btb_pkg::ST_FILL) || ent_cmd.we;
    ctr_raddr   = {cslot, (st == btb_pkg::ST_ENT) ? k_c : k_q};
    case (st)
      btb_pkg::ST_FILL: begin
        ctr_waddr = {CS_W'(slot_q), fill};
        ctr_wdata = fsm_init;
      end
      default: begin
        ctr_waddr = {cslot, k_q};
        ctr_wdata = trained;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= btb_pkg::ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= 3'd0;
      hist_len  <= 4'd1;
      tag_w     <= 5'd0;
      fsm_init  <= 2'd1;
      g_hist    <= 1'b0;
      g_tab     <= 1'b0;
      share     <= btb_pkg::SHARE_NONE;
    end else if (cfg_we) begin
      case (cfg.index)
        btb_pkg::CFG_SIZE_LOG2:   size_log2 <= cfg.data[2:0];
        btb_pkg::CFG_HIST_LEN:    hist_len  <= cfg.data[3:0];
        btb_pkg::CFG_TAG_WIDTH:   tag_w     <= cfg.data[4:0];
        btb_pkg::CFG_FSM_INIT:    fsm_init  <= cfg.data[1:0];
        btb_pkg::CFG_GLOBAL_HIST: g_hist    <= cfg.data[0];
        btb_pkg::CFG_GLOBAL_TAB:  g_tab     <= cfg.data[0];
        btb_pkg::CFG_SHARE_MODE:  share     <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      shist <= '0;
      bcnt  <= '0;
      fcnt  <= '0;
    end else if (ent_cmd.we) begin
      if (g_hist) begin
        shist <= hist_new;
      end
      if (bcnt != '1) begin
        bcnt <= bcnt + 32'd1;
      end
      if (wrong && (fcnt != '1)) begin
        fcnt <= fcnt + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (fire) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      mode_q  <= req.mode;
      pc_q    <= req.pc;
      tgt_q   <= req.target_pc;
      taken_q <= req.taken;
      prior_q <= req.prior_prediction;
      slot_q  <= slot_in;
      tag_q   <= tag_in;
    end
    if (st == btb_pkg::ST_ENT) begin
      hit_q  <= hit;
      hist_q <= h_eff;
      k_q    <= k_c;
      fill   <= '0;
    end else if (st == btb_pkg::ST_FILL) begin
      fill <= fill + HIST_MAX'(1);
    end
    if (fire) begin
      if (mode_q == btb_pkg::MODE_UPDATE) begin
        out_taken  <= 1'b0;
        out_target <= '0;
      end else begin
        out_taken  <= ptaken;
        out_target <= ptaken ? ent_rtarget : fall;
      end
    end
  end

  assign rsp.valid            = out_v;
  assign rsp.predict_taken    = out_taken;
  assign rsp.predicted_target = out_target;
  assign rsp.branch_count     = bcnt;
  assign rsp.flush_count      = fcnt;

  `BTB_CHECK(a_accept_reads_entry, (req.valid && req.ready) |=> (st == btb_pkg::ST_ENT), "accepted word did not start an entry read")
  `BTB_CHECK(a_ctr_write_state, ctr_cmd.we |-> ((st == btb_pkg::ST_FILL) || (st == btb_pkg::ST_CTR)), "counter write outside fill or train")
  `BTB_CHECK(a_update_counts, (ent_cmd.we && !cfg_we) |=> (bcnt != 32'd0), "update left branch count at zero")
  `BTB_CHECK_ALWAYS(a_reset_no_rsp, rst |=> !rsp.valid, "result word valid after reset")

endmodule

>>> sv/btb_two_level_branch_predictor.sv
// Direct-mapped branch target buffer with a two-level 2-bit counter predictor. Each word
// is a predict lookup or a resolved-branch update and yields one result word. Entries sit in
// a synchronous entry memory and counters in a counter memory; a lookup, a hit update and
// an update with a shared counter table go through entry read, counter read and
// result/write-back. An update that misses with per-entry counters also sweeps that entry's
// 2^HIST_MAX counters through the counter memory write port, one per cycle, before its
// counter read. A configuration write re-initializes valid bits, histories and counts
// at once. The result register lets the next word enter while a result waits.
module btb_two_level_branch_predictor #(
  parameter int BTB_DEPTH = btb_pkg::BTB_DEPTH_DEF,
  parameter int HIST_MAX  = btb_pkg::HIST_MAX_DEF
) (
  input logic       clk,
  input logic       rst,
  btb_req_if.sink   req,
  btb_rsp_if.source rsp,
  btb_cfg_if.sink   cfg
);

  localparam int IDX_W = (BTB_DEPTH > 1) ? $clog2(BTB_DEPTH) : 1;
  localparam int CS_W  = $clog2(BTB_DEPTH + 1);
  localparam int CA_W  = CS_W + HIST_MAX;

  logic                      clear;
  logic [1:0]                fsm_init;
  btb_pkg::mem_cmd_t         ent_cmd;
  logic [IDX_W-1:0]          ent_raddr;
  logic [IDX_W-1:0]          ent_waddr;
  logic [btb_pkg::TAG_W-1:0] ent_wtag;
  logic [31:0]               ent_wtarget;
  logic [HIST_MAX-1:0]       ent_whist;
  logic                      ent_rvalid;
  logic [btb_pkg::TAG_W-1:0] ent_rtag;
  logic [31:0]               ent_rtarget;
  logic [HIST_MAX-1:0]       ent_rhist;
  btb_pkg::mem_cmd_t         ctr_cmd;
  logic [CA_W-1:0]           ctr_raddr;
  logic [CA_W-1:0]           ctr_waddr;
  logic [1:0]                ctr_wdata;
  logic [1:0]                ctr_rdata;

  btb_ctrl #(.BTB_DEPTH(BTB_DEPTH), .HIST_MAX(HIST_MAX)) u_ctrl (
    .clk, .rst, .req, .rsp, .cfg,
    .clear, .fsm_init_o(fsm_init),
    .ent_cmd, .ent_raddr, .ent_waddr, .ent_wtag, .ent_wtarget, .ent_whist,
    .ent_rvalid, .ent_rtag, .ent_rtarget, .ent_rhist,
    .ctr_cmd, .ctr_raddr, .ctr_waddr, .ctr_wdata, .ctr_rdata
  );

  btb_entry_mem #(.BTB_DEPTH(BTB_DEPTH), .HIST_MAX(HIST_MAX)) u_entry_mem (
    .clk, .rst, .clear,
    .cmd(ent_cmd), .raddr(ent_raddr), .waddr(ent_waddr),
    .wtag(ent_wtag), .wtarget(ent_wtarget), .whist(ent_whist),
    .rvalid(ent_rvalid), .rtag(ent_rtag), .rtarget(ent_rtarget), .rhist(ent_rhist)
  );

  btb_ctr_mem #(.BTB_DEPTH(BTB_DEPTH), .HIST_MAX(HIST_MAX)) u_ctr_mem (
    .clk, .rst, .clear, .init(fsm_init),
    .cmd(ctr_cmd), .raddr(ctr_raddr), .waddr(ctr_waddr), .wdata(ctr_wdata),
    .rdata(ctr_rdata)
  );

endmodule
